// File: hdl/ble_pkg.sv
// ----------------------------------------------------------------------------
// Bounded list engine package
// Request codes, status codes, cell commands and controller states shared by
// the controller, the storage cells and the top level.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 7;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_TAIL = 3'd0,
    REQ_DEL_TAIL = 3'd1,
    REQ_INS_HEAD = 3'd2,
    REQ_DEL_HEAD = 3'd3,
    REQ_REVERSE  = 3'd4,
    REQ_INS_POS  = 3'd5,
    REQ_DEL_POS  = 3'd6
  } req_t;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  // What every cell does at the clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   value;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_ROT
  } ctrl_state_t;

endpackage

// File: hdl/ble_cell.sv
// ----------------------------------------------------------------------------
// Bounded list engine storage cell
// Holds one list entry and loads from its left or right neighbor, the
// broadcast value or the head entry, depending on the command and on where
// the cell sits relative to the broadcast position.
// ----------------------------------------------------------------------------
module ble_cell
  import ble_pkg::*;
#(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IW-1:0]     pos,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  input  logic [DATA_W-1:0] head_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] tap
);

  localparam logic [IW-1:0] ME = IW'(IDX);

  logic above;
  logic here;

  assign above = (ME > pos);
  assign here  = (ME == pos);

  // The entry at the broadcast position, for the removal read-out.
  assign tap = here ? data : '0;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INS: begin
        if (above) begin
          data <= left_data;
        end else if (here) begin
          data <= cmd.value;
        end
      end
      CELL_DEL: begin
        if (above || here) begin
          data <= right_data;
        end
      end
      CELL_ROT: begin
        if (!above && !here) begin
          data <= right_data;
        end else if (here) begin
          data <= head_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/ble_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded list engine controller
// Decodes requests, keeps the list length, drives the cell commands, runs the
// reversal sequence and holds the result register.
// ----------------------------------------------------------------------------
module ble_ctrl
  import ble_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int IW       = 6,
  parameter int LW       = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,
  input  logic [REQ_W-1:0]  s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,
  output logic [STAT_W-1:0] m_tuser,
  input  logic [DATA_W-1:0] head_data,
  input  logic [DATA_W-1:0] tap_data,
  output cell_cmd_t         cmd,
  output logic [IW-1:0]     pos
);

  localparam int PW = (LW > POS_W) ? LW : POS_W;

  ctrl_state_t       state, state_next;
  logic [LW-1:0]     length, length_next;
  logic [IW-1:0]     rot_pos, rot_pos_next;
  logic              accept;
  logic [STAT_W-1:0] st;
  logic [DATA_W-1:0] got;
  logic [PW-1:0]     len_x;
  logic [PW-1:0]     pos_x;
  logic [PW-1:0]     cnt_x;
  logic              full;
  logic              empty;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign len_x    = PW'(length);
  assign pos_x    = PW'(s_tdata[DATA_W +: POS_W]);
  assign full     = (length == LW'(CAPACITY));
  assign empty    = (length == '0);
  assign cnt_x    = PW'(length_next);

  always_comb begin
    state_next   = state;
    length_next  = length;
    rot_pos_next = rot_pos;
    cmd.op       = CELL_HOLD;
    cmd.value    = s_tdata[DATA_W-1:0];
    pos          = '0;
    st           = ST_OK;
    got          = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_t'(s_tuser))
            REQ_INS_TAIL: begin
              if (full) begin
                st = ST_FULL;
              end else begin
                cmd.op      = CELL_INS;
                pos         = IW'(length);
                length_next = length + LW'(1);
              end
            end
            REQ_DEL_TAIL: begin
              if (empty) begin
                st = ST_ABSENT;
              end else begin
                cmd.op      = CELL_DEL;
                pos         = IW'(length - LW'(1));
                got         = tap_data;
                length_next = length - LW'(1);
              end
            end
            REQ_INS_HEAD: begin
              if (full) begin
                st = ST_FULL;
              end else begin
                cmd.op      = CELL_INS;
                length_next = length + LW'(1);
              end
            end
            REQ_DEL_HEAD: begin
              if (empty) begin
                st = ST_ABSENT;
              end else begin
                cmd.op      = CELL_DEL;
                got         = tap_data;
                length_next = length - LW'(1);
              end
            end
            REQ_REVERSE: begin
              if (empty) begin
                st = ST_ABSENT;
              end else if (length != LW'(1)) begin
                // First rotation step runs now; the rest in S_ROT.
                cmd.op = CELL_ROT;
                pos    = IW'(length - LW'(1));
                if (length != LW'(2)) begin
                  rot_pos_next = IW'(length - LW'(2));
                  state_next   = S_ROT;
                end
              end
            end
            REQ_INS_POS: begin
              if (full) begin
                st = ST_FULL;
              end else if (pos_x == '0 || pos_x > len_x + PW'(1)) begin
                st = ST_ABSENT;
              end else begin
                cmd.op      = CELL_INS;
                pos         = IW'(pos_x - PW'(1));
                length_next = length + LW'(1);
              end
            end
            REQ_DEL_POS: begin
              if (pos_x == '0 || pos_x > len_x) begin
                st = ST_ABSENT;
              end else begin
                cmd.op      = CELL_DEL;
                pos         = IW'(pos_x - PW'(1));
                got         = tap_data;
                length_next = length - LW'(1);
              end
            end
            default: begin
              st = ST_OK;
            end
          endcase
        end
      end
      S_ROT: begin
        cmd.op = CELL_ROT;
        pos    = rot_pos;
        if (rot_pos == IW'(1)) begin
          state_next = S_IDLE;
        end else begin
          rot_pos_next = rot_pos - IW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      length   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rot_pos <= rot_pos_next;
    if (accept) begin
      m_tdata <= {1'b0, cnt_x[CNT_W-1:0], got};
      m_tuser <= st;
    end
  end

  // No request is taken while the reversal sequence runs.
  a_no_accept_in_rot: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) |-> !s_tready)
    else $error("request accepted during reversal");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LW'(CAPACITY))
    else $error("list length beyond capacity");

  // A full report always comes with a full list count.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |->
      (m_tdata[DATA_W +: CNT_W] == CNT_W'(CAPACITY)))
    else $error("full status with wrong count");

endmodule

// File: hdl/bounded_list_engine_top.sv
// ----------------------------------------------------------------------------
// Bounded list engine top level
// An ordered list of signed 32-bit values kept in a row of storage cells.
// ----------------------------------------------------------------------------
// Result: the result item is registered and offered in the cycle after its
//   request item is accepted.
// Throughput: one item per cycle for inserts and removals while results are taken;
//   a reversal of n entries runs n-1 rotation steps of the cell row, one per cycle
//   from the accepting cycle on, and the input is held until the last step runs.
// Reset: rst (synchronous) empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module bounded_list_engine_top
  import ble_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,   // value[31:0], position[38:32], zero[39]
  input  logic [REQ_W-1:0]  s_tuser,   // req_type[2:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // removed_value[31:0], count[38:32], zero[39]
  output logic [STAT_W-1:0] m_tuser    // status[1:0]
);

  // Index width addresses every cell; the length counter also holds CAPACITY.
  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  cell_cmd_t         cmd;
  logic [IW-1:0]     pos;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_tap  [CAPACITY];
  logic [DATA_W-1:0] tap_data;

  // The controller decodes each request item into one command that every
  // cell sees together with a broadcast position. Inserts shift the cells
  // above the position one step toward the tail; removals shift them one
  // step toward the head. A reversal is a series of rotations: in each step
  // the head entry moves to a position that walks down from the tail, and
  // the cells below that position shift toward the head.
  ble_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .LW       (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .head_data (cell_data[0]),
    .tap_data  (tap_data),
    .cmd       (cmd),
    .pos       (pos)
  );

  // The cell row. The ends see zero from their missing neighbor; those
  // values only ever land in cells beyond the list length.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    ble_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos),
      .left_data  (left_data),
      .right_data (right_data),
      .head_data  (cell_data[0]),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // Exactly one cell matches the position, so an OR of the taps reads out
  // the entry that a removal takes.
  always_comb begin
    tap_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_data = tap_data | cell_tap[i];
    end
  end

endmodule

// File: dv/bounded_list_checker.sv
// ----------------------------------------------------------------------------
// Bounded list engine checker
// Watches the request and result channels, keeps its own copy of the list,
// predicts every result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module bounded_list_checker
  import ble_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [39:0]       s_tdata,   // value[31:0], position[38:32], zero[39]
  input  logic [REQ_W-1:0]  s_tuser,   // req_type[2:0]
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [39:0]       m_tdata,   // removed_value[31:0], count[38:32], zero[39]
  input  logic [STAT_W-1:0] m_tuser,   // status[1:0]
  output int                errors,
  output int                pending_results,
  output int                list_held,
  output int                results_checked
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] removed;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic [DATA_W-1:0] list_words[$];
  list_result_t      awaited_results[$];

  function automatic logic [STAT_W-1:0] place_word(int idx, logic [DATA_W-1:0] val);
    if (list_words.size() >= CAPACITY) return ST_FULL;
    if (idx > list_words.size()) return ST_ABSENT;
    list_words.insert(idx, val);
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] take_word(int idx, output logic [DATA_W-1:0] got);
    got = '0;
    if (list_words.size() == 0 || idx >= list_words.size()) return ST_ABSENT;
    got = list_words[idx];
    list_words.delete(idx);
    return ST_OK;
  endfunction

  function automatic list_result_t apply_request(logic [REQ_W-1:0] code,
                                                 logic [DATA_W-1:0] val,
                                                 logic [POS_W-1:0] pos);
    list_result_t r;
    logic [DATA_W-1:0] got;
    got      = '0;
    r.status = ST_OK;
    case (code)
      REQ_INS_TAIL: r.status = place_word(list_words.size(), val);
      REQ_DEL_TAIL: begin
        if (list_words.size() == 0) r.status = ST_ABSENT;
        else r.status = take_word(list_words.size() - 1, got);
      end
      REQ_INS_HEAD: r.status = place_word(0, val);
      REQ_DEL_HEAD: r.status = take_word(0, got);
      REQ_REVERSE: begin
        if (list_words.size() == 0) r.status = ST_ABSENT;
        else list_words.reverse();
      end
      REQ_INS_POS: begin
        // A full list is reported before a bad position is looked at.
        if (list_words.size() >= CAPACITY) r.status = ST_FULL;
        else if (pos == 0) r.status = ST_ABSENT;
        else r.status = place_word(int'(pos) - 1, val);
      end
      REQ_DEL_POS: begin
        if (pos == 0) r.status = ST_ABSENT;
        else r.status = take_word(int'(pos) - 1, got);
      end
      default: r.status = ST_OK;
    endcase
    r.removed = got;
    r.count   = CNT_W'(list_words.size());
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    list_result_t seen;
    if (rst) begin
      list_words.delete();
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.status  = m_tuser;
        seen.removed = m_tdata[31:0];
        seen.count   = m_tdata[38:32];
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item, status %0d removed %0d count %0d",
                   $time, seen.status, $signed(seen.removed), seen.count);
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (seen.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, seen.status);
          end
          if (seen.removed !== want.removed) begin
            errors++;
            $display("%0t: removed value mismatch, expected %0d, got %0d",
                     $time, $signed(want.removed), $signed(seen.removed));
          end
          if (seen.count !== want.count) begin
            errors++;
            $display("%0t: count mismatch, expected %0d, got %0d",
                     $time, want.count, seen.count);
          end
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(apply_request(s_tuser, s_tdata[31:0], s_tdata[38:32]));
    end
    pending_results = awaited_results.size();
    list_held       = list_words.size();
  end

endmodule

// File: dv/tb_bounded_list_engine_top.sv
// ----------------------------------------------------------------------------
// Bounded list engine testbench
// Drives list requests through the stream input under several idle and stall
// mixes, fills the list to capacity and drains it, and lets the checker
// predict and compare every result item.
// ----------------------------------------------------------------------------
module tb_bounded_list_engine_top;
  import ble_pkg::*;

  localparam int CAPACITY    = 64;
  // Worst case is far below this: a full reversal holds the input during its rotation
  // steps, and idle and stall phases roughly double the time of each item.
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 150;

  // The request code that the package leaves unused; the block must answer it
  // with an ok status and leave the list alone.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [39:0]       s_tdata;   // value[31:0], position[38:32], zero[39]
  logic [REQ_W-1:0]  s_tuser;   // req_type[2:0]
  logic              m_tvalid;
  logic              m_tready;
  logic [39:0]       m_tdata;   // removed_value[31:0], count[38:32], zero[39]
  logic [STAT_W-1:0] m_tuser;   // status[1:0]

  int errors;
  int pending_results;
  int list_held;
  int results_checked;

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int items_sent      = 0;
  int cycle_count     = 0;
  int hold_left       = 0;
  bit hold_request    = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bounded_list_engine_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  bounded_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .errors(errors),
    .pending_results(pending_results),
    .list_held(list_held),
    .results_checked(results_checked)
  );

  // Watchdog. A hang anywhere in the handshakes ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result receiver. It stalls at the rate of the current phase, and when the
  // stimulus asks for it, it holds off for a long stretch so that the result
  // register stays full and the block has to drop s_tready.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Offers one request item and returns at the falling edge after it was
  // taken. It is always entered at a falling edge. Idle cycles come first, so
  // s_tvalid is written at most once in any time step.
  task automatic send_item(input logic [REQ_W-1:0] code, input logic [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, pos, val};
    s_tuser  <= code;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Any insert kind, with a position that is always valid for the list as the
  // checker holds it right now.
  task automatic send_insert(input logic [DATA_W-1:0] val);
    logic [REQ_W-1:0] code;
    case ($urandom_range(0, 2))
      0:       code = REQ_INS_TAIL;
      1:       code = REQ_INS_HEAD;
      default: code = REQ_INS_POS;
    endcase
    send_item(code, val, POS_W'($urandom_range(1, list_held + 1)));
  endtask

  // One random request. The mix tilts the list toward full or empty so that
  // both ends are visited often; positions mostly land inside the list, with
  // zero, just past the end and any 7-bit value mixed in.
  task automatic issue_random(input mix_t mix);
    int                roll;
    int                ins_share;
    logic [REQ_W-1:0]  code;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0]  pos;
    ins_share = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      code = REQ_UNUSED;
    end else if (roll < 9) begin
      code = REQ_REVERSE;
    end else if ($urandom_range(0, 99) < ins_share) begin
      case ($urandom_range(0, 2))
        0:       code = REQ_INS_TAIL;
        1:       code = REQ_INS_HEAD;
        default: code = REQ_INS_POS;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       code = REQ_DEL_TAIL;
        1:       code = REQ_DEL_HEAD;
        default: code = REQ_DEL_POS;
      endcase
    end
    if ($urandom_range(0, 99) < 8) begin
      case ($urandom_range(0, 3))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7fff_ffff;
        2:       val = '0;
        default: val = '1;
      endcase
    end else begin
      val = $urandom;
    end
    roll = $urandom_range(0, 99);
    if (roll < 70)      pos = POS_W'($urandom_range(1, list_held + 1));
    else if (roll < 80) pos = '0;
    else if (roll < 90) pos = POS_W'(list_held + $urandom_range(1, 3));
    else                pos = POS_W'($urandom_range(0, 127));
    send_item(code, val, pos);
  endtask

  initial begin
    mix_t mix;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: each removal kind and a reversal on an empty list, the value extremes,
    // positional inserts at the head, the middle and just past the tail,
    // removals at bad positions, the unused code, and reversal of lists with
    // several entries and with one entry.
    send_item(REQ_DEL_TAIL, '0, '0);
    send_item(REQ_DEL_HEAD, '0, '0);
    send_item(REQ_DEL_POS,  '0, 7'd1);
    send_item(REQ_REVERSE,  '0, '0);
    send_item(REQ_INS_POS,  32'h1111_1111, 7'd0);
    send_item(REQ_INS_POS,  32'h2222_2222, 7'd2);
    send_item(REQ_INS_POS,  32'h8000_0000, 7'd1);
    send_item(REQ_INS_TAIL, 32'h7fff_ffff, '0);
    send_item(REQ_INS_HEAD, 32'h0000_0000, '0);
    send_item(REQ_INS_POS,  32'hffff_ffff, 7'd4);
    send_item(REQ_INS_POS,  32'h1234_5678, 7'd2);
    send_item(REQ_REVERSE,  '0, '0);
    send_item(REQ_DEL_POS,  '0, 7'd5);
    send_item(REQ_DEL_POS,  '0, 7'd0);
    send_item(REQ_DEL_POS,  '0, 7'd5);
    send_item(REQ_UNUSED,   32'hdead_beef, 7'd127);
    send_item(REQ_DEL_HEAD, '0, '0);
    send_item(REQ_DEL_TAIL, '0, '0);
    send_item(REQ_DEL_POS,  '0, 7'd127);
    send_item(REQ_REVERSE,  '0, '0);
    send_item(REQ_DEL_POS,  '0, 7'd1);
    send_item(REQ_REVERSE,  '0, '0);
    send_item(REQ_DEL_POS,  '0, 7'd1);

    // Fill to capacity, then show that every insert kind is refused on a full
    // list, a bad position included, and reverse the full list.
    while (list_held < CAPACITY) send_insert($urandom);
    send_item(REQ_INS_TAIL, 32'h5555_5555, '0);
    send_item(REQ_INS_HEAD, 32'haaaa_aaaa, '0);
    send_item(REQ_INS_POS,  32'h0f0f_0f0f, 7'd0);
    send_item(REQ_INS_POS,  32'hf0f0_f0f0, 7'd100);
    send_item(REQ_REVERSE,  '0, '0);
    send_item(REQ_DEL_POS,  '0, 7'd64);
    send_item(REQ_DEL_POS,  '0, 7'd64);

    // Random part in four phases: no idling, an idle sender, a stalling
    // receiver, and light idling on both sides.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 50; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 50; end
        default: begin sender_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      mix = MIX_FILL;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) mix = mix_t'($urandom_range(0, 2));
        // Long receiver hold-off while requests keep coming.
        if (phase == 0 && n == 60) hold_request = 1'b1;
        // Sender goes quiet until the block has answered everything.
        if (phase == 1 && n == 75) begin
          s_tvalid <= 1'b0;
          wait (pending_results == 0);
          @(negedge clk);
        end
        issue_random(mix);
      end
      s_tvalid <= 1'b0;
      wait (pending_results == 0);
      @(negedge clk);
    end

    s_tvalid <= 1'b0;
    wait (pending_results == 0);
    // Results come from a register behind the request; the closing wait makes sure
    // nothing stray comes out afterwards.
    repeat (8) @(posedge clk);

    $display("Sent %0d request items (directed cases, a fill to capacity and four idle/stall",
             items_sent);
    $display("mixes with a long receiver hold-off); %0d result items were checked.",
             results_checked);
    if (errors == 0 && pending_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: bounded_list_engine_top.f
hdl/ble_pkg.sv
hdl/ble_cell.sv
hdl/ble_ctrl.sv
hdl/bounded_list_engine_top.sv
dv/bounded_list_checker.sv
dv/tb_bounded_list_engine_top.sv
